// ----- rtl/core/sws_pkg.sv -----
// Shared types and constants of the sliding window sender.
// Used by every module under rtl/core; depends on nothing else.
package sws_pkg;

   localparam int FRAME_BYTES = 1468;
   localparam int WINDOW_MAX  = 64;

   localparam int SEQ_W   = 22;
   localparam int LEN_W   = 11;
   localparam int WIN_W   = 7;
   localparam int MS_W    = 16;
   localparam int TOTAL_W = 32;
   localparam int IDX_W   = 2;

   localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};
   localparam logic [MS_W-1:0]  MS_MAX  = {MS_W{1'b1}};

   // Configuration reset values.
   localparam logic [TOTAL_W-1:0] TOTAL_RST    = '0;
   localparam logic [WIN_W-1:0]   WINDOW_RST   = WIN_W'(8);
   localparam logic [MS_W-1:0]    TIMEOUT_RST  = MS_W'(40);
   localparam logic [MS_W-1:0]    MIN_RTT_RST  = MS_W'(20);

   // Register indexes on the configuration port.
   localparam logic [IDX_W-1:0] REG_TOTAL_BYTES     = 2'd0;
   localparam logic [IDX_W-1:0] REG_INITIAL_WINDOW  = 2'd1;
   localparam logic [IDX_W-1:0] REG_INITIAL_TIMEOUT = 2'd2;
   localparam logic [IDX_W-1:0] REG_MIN_RTT         = 2'd3;

   // Input mode codes.
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_ACK   = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_ACK,
      CMD_TICK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [SEQ_W-1:0] ack;
   } cmd_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] total_bytes;
      logic [WIN_W-1:0]   initial_window;
      logic [MS_W-1:0]    initial_timeout;
      logic [MS_W-1:0]    min_rtt;
   } cfg_type;

   typedef struct packed {
      logic [SEQ_W-1:0] frame_count;
      logic [LEN_W-1:0] last_length;
   } div_result_type;

endpackage

// ----- rtl/core/sws_front.sv -----
// Front end of the sliding window sender: accepts input transactions,
// classifies them into commands and queues them for the back end.
// Depends on sws_pkg.
module sws_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,  // [21:0] ack_value, [23:22] zero
   input  logic [1:0]        req_tuser,  // [1:0] mode
   output logic              cmd_valid,
   output sws_pkg::cmd_type  cmd,
   input  logic              cmd_pop
);

   sws_pkg::cmd_type queue_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   sws_pkg::cmd_type new_cmd;
   logic             keep;
   logic             push;
   logic             pop;

   always_comb begin
      new_cmd.ack  = req_tdata[sws_pkg::SEQ_W-1:0];
      new_cmd.kind = sws_pkg::CMD_START;
      keep         = 1'b1;
      case (req_tuser)
         sws_pkg::MODE_START: new_cmd.kind = sws_pkg::CMD_START;
         sws_pkg::MODE_ACK:   new_cmd.kind = sws_pkg::CMD_ACK;
         sws_pkg::MODE_TICK:  new_cmd.kind = sws_pkg::CMD_TICK;
         // The unused mode is accepted and dropped here.
         default:             keep = 1'b0;
      endcase
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready && keep;
   assign pop        = cmd_pop && (count_ff != 2'd0);
   assign cmd_valid  = (count_ff != 2'd0);
   assign cmd        = queue_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ----- rtl/core/sws_frame_div.sv -----
// Constant divider that turns the byte total into a frame count and the
// length of the last frame with a reciprocal multiply and a correction step.
// Depends on sws_pkg.
module sws_frame_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [sws_pkg::TOTAL_W-1:0] total_bytes,
   output logic                        done,
   output sws_pkg::div_result_type     result
);

   localparam int TW     = sws_pkg::TOTAL_W;
   localparam int REM_W  = sws_pkg::LEN_W + 1;
   localparam int MAG_W  = TW + 1;
   localparam int PROD_W = 2 * TW;
   localparam logic [REM_W-1:0] DIVISOR   = REM_W'(sws_pkg::FRAME_BYTES);
   localparam logic [TW-1:0]    DIVISOR_W = TW'(sws_pkg::FRAME_BYTES);
   // The reciprocal is rounded down, so the first quotient estimate is
   // either exact or one below the true quotient.
   localparam logic [MAG_W-1:0] MAGIC = MAG_W'((64'd1 << TW) / sws_pkg::FRAME_BYTES);

   logic [3:0]        stage_ff;
   logic              done_ff;
   logic [TW-1:0]     dvd_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [TW-1:0]     quot_ff;
   logic [REM_W-1:0]  rem_ff;

   logic [TW-1:0]     back_prod;
   logic [TW-1:0]     rem_wide;
   logic [TW:0]       count_wide;

   always_comb begin
      back_prod = quot_ff * DIVISOR_W;
      rem_wide  = dvd_ff - back_prod;
   end

   // Round up when a partial frame remains; a zero remainder means the last
   // frame is a whole one.
   always_comb begin
      count_wide = {1'b0, quot_ff} + {{TW{1'b0}}, (rem_ff != '0)};
      if (count_wide > {{(TW + 1 - sws_pkg::SEQ_W){1'b0}}, sws_pkg::SEQ_MAX}) begin
         result.frame_count = sws_pkg::SEQ_MAX;
      end else begin
         result.frame_count = count_wide[sws_pkg::SEQ_W-1:0];
      end
      if (rem_ff == '0) begin
         result.last_length = sws_pkg::LEN_W'(sws_pkg::FRAME_BYTES);
      end else begin
         result.last_length = rem_ff[sws_pkg::LEN_W-1:0];
      end
   end

   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= {stage_ff[2:0], start};
         done_ff  <= stage_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= total_bytes;
      end
      if (stage_ff[0]) begin
         prod_ff <= PROD_W'(dvd_ff * MAGIC);
      end
      if (stage_ff[1]) begin
         quot_ff <= prod_ff[PROD_W-1:TW];
      end else if (stage_ff[3] && (rem_ff >= DIVISOR)) begin
         quot_ff <= quot_ff + TW'(1);
      end
      if (stage_ff[2]) begin
         rem_ff <= rem_wide[REM_W-1:0];
      end else if (stage_ff[3] && (rem_ff >= DIVISOR)) begin
         rem_ff <= rem_ff - DIVISOR;
      end
   end

endmodule

// ----- rtl/core/sws_back.sv -----
// Back end of the sliding window sender: holds the transfer state, runs the
// rounds and drives the registered result channel. Depends on sws_pkg.
module sws_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   input  sws_pkg::cmd_type             cmd,
   output logic                         cmd_pop,
   input  sws_pkg::cfg_type             cfg,
   output logic                         div_start,
   input  logic                         div_done,
   input  sws_pkg::div_result_type      div_res,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [sws_pkg::SEQ_W-1:0]    rsp_seq,
   output logic [sws_pkg::LEN_W-1:0]    rsp_len,
   output logic                         rsp_hdr,
   output logic                         rsp_done,
   output logic                         rsp_last
);

   localparam int SW = sws_pkg::SEQ_W;
   localparam int WW = sws_pkg::WIN_W;
   localparam int MW = sws_pkg::MS_W;
   localparam logic [WW-1:0] WIN_MIN = WW'(2);
   localparam logic [WW-1:0] WIN_TOP = WW'(sws_pkg::WINDOW_MAX);

   typedef enum logic [2:0] {
      ST_WAIT,
      ST_DIV,
      ST_HDR,
      ST_END,
      ST_ROUND,
      ST_BURST
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HANDSHAKE,
      PH_RUNNING,
      PH_DONE
   } phase_type;

   state_type     state_ff;
   phase_type     phase_ff;
   logic [SW-1:0] base_ff;
   logic [SW-1:0] round_end_ff;
   logic [WW-1:0] window_ff;
   logic [MW-1:0] timeout_ff;
   logic [MW-1:0] rtt_ff;
   logic [MW-1:0] elapsed_ff;
   logic [SW-1:0] frames_ff;
   logic [sws_pkg::LEN_W-1:0] last_len_ff;
   logic          all_acked_ff;
   logic [SW-1:0] seq_ff;

   logic          rsp_valid_ff;
   logic [SW-1:0] rsp_seq_ff;
   logic [sws_pkg::LEN_W-1:0] rsp_len_ff;
   logic          rsp_hdr_ff;
   logic          rsp_done_ff;
   logic          rsp_last_ff;

   logic          out_free;
   logic [WW-1:0] win_start;
   logic [WW:0]   win_double;
   logic [WW-1:0] win_in;
   logic [SW-1:0] ack_clamped;
   logic [MW:0]   rtt_double;
   logic [MW-1:0] rtt_in;
   logic [MW-1:0] elapsed_in;
   logic [SW:0]   end_wide;
   logic [SW-1:0] round_end_in;
   logic [SW:0]   seq_next;
   logic          burst_last;
   logic [sws_pkg::LEN_W-1:0] frame_len;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign cmd_pop   = (state_ff == ST_WAIT) && cmd_valid;
   assign div_start = cmd_pop && (cmd.kind == sws_pkg::CMD_START);

   always_comb begin
      win_start = cfg.initial_window;
      if (win_start < WIN_MIN) begin
         win_start = WIN_MIN;
      end else if (win_start > WIN_TOP) begin
         win_start = WIN_TOP;
      end

      win_double = {window_ff, 1'b0};
      if (all_acked_ff) begin
         win_in = (win_double > {1'b0, WIN_TOP}) ? WIN_TOP : win_double[WW-1:0];
      end else begin
         win_in = ((window_ff >> 1) < WIN_MIN) ? WIN_MIN : (window_ff >> 1);
      end

      ack_clamped = (cmd.ack > frames_ff) ? frames_ff : cmd.ack;

      rtt_double = {elapsed_ff, 1'b0};
      rtt_in     = rtt_double[MW] ? sws_pkg::MS_MAX : rtt_double[MW-1:0];

      elapsed_in = (elapsed_ff == sws_pkg::MS_MAX) ? elapsed_ff : (elapsed_ff + MW'(1));

      end_wide     = {1'b0, base_ff} + (SW + 1)'(window_ff);
      round_end_in = (end_wide > {1'b0, frames_ff}) ? frames_ff : end_wide[SW-1:0];

      seq_next   = {1'b0, seq_ff} + (SW + 1)'(1);
      burst_last = (seq_next[SW-1:0] == round_end_ff);
      frame_len  = (seq_next < {1'b0, frames_ff}) ?
                   sws_pkg::LEN_W'(sws_pkg::FRAME_BYTES) : last_len_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WAIT;
         phase_ff     <= PH_IDLE;
         base_ff      <= '0;
         round_end_ff <= '0;
         window_ff    <= sws_pkg::WINDOW_RST;
         timeout_ff   <= sws_pkg::TIMEOUT_RST;
         rtt_ff       <= sws_pkg::TIMEOUT_RST;
         elapsed_ff   <= '0;
         frames_ff    <= '0;
         last_len_ff  <= '0;
         all_acked_ff <= 1'b0;
         seq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_WAIT: begin
               if (cmd_valid) begin
                  case (cmd.kind)
                     sws_pkg::CMD_START: begin
                        window_ff    <= win_start;
                        timeout_ff   <= cfg.initial_timeout;
                        rtt_ff       <= cfg.initial_timeout;
                        base_ff      <= '0;
                        round_end_ff <= '0;
                        elapsed_ff   <= '0;
                        phase_ff     <= PH_HANDSHAKE;
                        state_ff     <= ST_DIV;
                     end
                     sws_pkg::CMD_ACK: begin
                        if (phase_ff == PH_HANDSHAKE) begin
                           phase_ff <= PH_RUNNING;
                           base_ff  <= '0;
                           state_ff <= ST_ROUND;
                        end else if (phase_ff == PH_RUNNING && ack_clamped > base_ff) begin
                           base_ff <= ack_clamped;
                           rtt_ff  <= rtt_in;
                           if (ack_clamped >= round_end_ff) begin
                              all_acked_ff <= 1'b1;
                              state_ff     <= ST_END;
                           end
                        end
                     end
                     sws_pkg::CMD_TICK: begin
                        if (phase_ff == PH_HANDSHAKE) begin
                           state_ff <= ST_HDR;
                        end else if (phase_ff == PH_RUNNING) begin
                           elapsed_ff <= elapsed_in;
                           if (elapsed_in >= timeout_ff) begin
                              all_acked_ff <= 1'b0;
                              state_ff     <= ST_END;
                           end
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  frames_ff   <= div_res.frame_count;
                  last_len_ff <= div_res.last_length;
                  state_ff    <= ST_HDR;
               end
            end
            ST_HDR: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_seq_ff   <= frames_ff;
                  rsp_len_ff   <= '0;
                  rsp_hdr_ff   <= 1'b1;
                  rsp_done_ff  <= 1'b0;
                  rsp_last_ff  <= 1'b1;
                  state_ff     <= ST_WAIT;
               end
            end
            ST_END: begin
               window_ff <= win_in;
               if (rtt_ff < cfg.min_rtt) begin
                  rtt_ff     <= cfg.initial_timeout;
                  timeout_ff <= cfg.initial_timeout;
               end else begin
                  timeout_ff <= rtt_ff;
               end
               state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               elapsed_ff <= '0;
               if (base_ff >= frames_ff) begin
                  // Everything is acknowledged: report completion once.
                  phase_ff     <= PH_DONE;
                  round_end_ff <= base_ff;
                  if (out_free) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_seq_ff   <= '0;
                     rsp_len_ff   <= '0;
                     rsp_hdr_ff   <= 1'b0;
                     rsp_done_ff  <= 1'b1;
                     rsp_last_ff  <= 1'b1;
                     state_ff     <= ST_WAIT;
                  end
               end else begin
                  round_end_ff <= round_end_in;
                  seq_ff       <= base_ff;
                  state_ff     <= ST_BURST;
               end
            end
            ST_BURST: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_seq_ff   <= seq_ff;
                  rsp_len_ff   <= frame_len;
                  rsp_hdr_ff   <= 1'b0;
                  rsp_done_ff  <= 1'b0;
                  rsp_last_ff  <= burst_last;
                  seq_ff       <= seq_next[SW-1:0];
                  if (burst_last) begin
                     state_ff <= ST_WAIT;
                  end
               end
            end
            default: begin
               state_ff <= ST_WAIT;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_seq    = rsp_seq_ff;
   assign rsp_len    = rsp_len_ff;
   assign rsp_hdr    = rsp_hdr_ff;
   assign rsp_done   = rsp_done_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// ----- rtl/core/sliding_window_sender_unit.sv -----
// Top level of the sliding window sender: configuration registers and the
// front end, divider and back end. Depends on sws_pkg and the sws_ modules.
//
// Usage. Events arrive on the req_ stream: tuser carries the mode (start,
// ack, one ms tick), tdata the cumulative ack number. Send commands leave
// on the rsp_ stream: tdata carries sequence and payload length, tuser the
// header and completion flags, tlast marks the last result of one event.
// The csr_ channel writes the four registers and is always ready; write
// only while the block is idle.
// An event is registered in the front-end queue and leaves it when the back
// end waits. A start runs the reciprocal divide and the header is registered
// once it is done; a tick in the handshake resends it. An ack that ends a
// round or a tick that times it out passes the round end state, the ack that
// ends the handshake goes straight to the round start state, which reports
// completion or opens a burst; then one send command per cycle follows while
// the receiver is ready, up to the window size (at most 64). The front end
// queues two events, so two more transactions are taken while a burst is
// delivered. When the receiver stalls, the output register holds its
// transaction and the back end waits; the queue fills and req_tready drops.
// Reset is synchronous: the block goes idle with the default registers.
module sliding_window_sender_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [21:0] ack_value, [23:22] zero
   input  logic [1:0]  req_tuser,  // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [21:0] send_seq, [32:22] send_length, [39:33] zero
   output logic [1:0]  rsp_tuser,  // [0] is_header, [1] transfer_done
   output logic        rsp_tlast,  // last_of_run
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   sws_pkg::cfg_type        cfg_ff;
   sws_pkg::cmd_type        cmd;
   sws_pkg::div_result_type div_res;
   logic                    cmd_valid;
   logic                    cmd_pop;
   logic                    div_start;
   logic                    div_done;
   logic [sws_pkg::SEQ_W-1:0] rsp_seq;
   logic [sws_pkg::LEN_W-1:0] rsp_len;
   logic                    rsp_hdr;
   logic                    rsp_done;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.total_bytes     <= sws_pkg::TOTAL_RST;
         cfg_ff.initial_window  <= sws_pkg::WINDOW_RST;
         cfg_ff.initial_timeout <= sws_pkg::TIMEOUT_RST;
         cfg_ff.min_rtt         <= sws_pkg::MIN_RTT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sws_pkg::REG_TOTAL_BYTES:
               cfg_ff.total_bytes <= csr_data;
            sws_pkg::REG_INITIAL_WINDOW:
               cfg_ff.initial_window <= csr_data[sws_pkg::WIN_W-1:0];
            sws_pkg::REG_INITIAL_TIMEOUT:
               cfg_ff.initial_timeout <= csr_data[sws_pkg::MS_W-1:0];
            sws_pkg::REG_MIN_RTT:
               cfg_ff.min_rtt <= csr_data[sws_pkg::MS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   sws_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   sws_frame_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .total_bytes (cfg_ff.total_bytes),
      .done        (div_done),
      .result      (div_res)
   );

   sws_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .cfg        (cfg_ff),
      .div_start  (div_start),
      .div_done   (div_done),
      .div_res    (div_res),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_seq    (rsp_seq),
      .rsp_len    (rsp_len),
      .rsp_hdr    (rsp_hdr),
      .rsp_done   (rsp_done),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, rsp_len, rsp_seq};
   assign rsp_tuser = {rsp_done, rsp_hdr};

endmodule

// ----- tb/sws_send_check_pkg.sv -----
// Scoreboard of the sliding window sender testbench: it tracks the transfer
// state, predicts the send commands for every event and checks the results.
// Depends on sws_pkg for widths, register indexes and mode codes.
package sws_send_check_pkg;

   import sws_pkg::*;

   // The mode field is two bits wide; this code has no meaning and is ignored.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      XFER_IDLE,
      XFER_HANDSHAKE,
      XFER_RUNNING,
      XFER_DONE
   } xfer_phase_e;

   typedef struct packed {
      logic [SEQ_W-1:0] seq;
      logic [LEN_W-1:0] len;
      logic             header;
      logic             done;
      logic             last;
   } send_cmd_t;

   class send_cmd_scoreboard;

      logic [TOTAL_W-1:0] total_bytes;
      logic [WIN_W-1:0]   init_window;
      logic [MS_W-1:0]    init_timeout;
      logic [MS_W-1:0]    min_rtt;

      xfer_phase_e        phase;
      logic [SEQ_W-1:0]   base_frame;
      logic [SEQ_W-1:0]   round_end;
      logic [SEQ_W-1:0]   frame_count;
      int unsigned        window_size;
      logic [MS_W-1:0]    round_timeout;
      logic [MS_W-1:0]    rtt_estimate;
      logic [MS_W-1:0]    elapsed_ms;
      logic [LEN_W-1:0]   last_length;

      send_cmd_t          expected_sends[$];
      int unsigned        mismatches;

      function new();
         total_bytes   = TOTAL_RST;
         init_window   = WINDOW_RST;
         init_timeout  = TIMEOUT_RST;
         min_rtt       = MIN_RTT_RST;
         phase         = XFER_IDLE;
         base_frame    = '0;
         round_end     = '0;
         frame_count   = '0;
         window_size   = init_window;
         round_timeout = init_timeout;
         rtt_estimate  = init_timeout;
         elapsed_ms    = '0;
         last_length   = '0;
         mismatches    = 0;
      endfunction

      function void note_config(logic [IDX_W-1:0] index, logic [TOTAL_W-1:0] value);
         case (index)
            REG_TOTAL_BYTES:     total_bytes  = value;
            REG_INITIAL_WINDOW:  init_window  = value[WIN_W-1:0];
            REG_INITIAL_TIMEOUT: init_timeout = value[MS_W-1:0];
            REG_MIN_RTT:         min_rtt      = value[MS_W-1:0];
            default: ;
         endcase
      endfunction

      function void push_send(logic [SEQ_W-1:0] seq, logic [LEN_W-1:0] len,
                              logic header, logic done);
         send_cmd_t cmd;
         cmd.seq    = seq;
         cmd.len    = len;
         cmd.header = header;
         cmd.done   = done;
         cmd.last   = 1'b0;
         expected_sends.push_back(cmd);
      endfunction

      // A new round sends the burst from the base up to the window, or the
      // completion status once every frame is acknowledged.
      function void open_round();
         int unsigned stop;
         int unsigned s;
         elapsed_ms = '0;
         if (base_frame >= frame_count) begin
            phase     = XFER_DONE;
            round_end = base_frame;
            push_send('0, '0, 1'b0, 1'b1);
            return;
         end
         stop = base_frame + window_size;
         if (stop > frame_count)
            stop = frame_count;
         round_end = SEQ_W'(stop);
         for (s = base_frame; s < stop; s++)
            push_send(SEQ_W'(s), (s + 1 < frame_count) ? LEN_W'(FRAME_BYTES) : last_length,
                      1'b0, 1'b0);
      endfunction

      function void close_round(bit all_acked);
         if (all_acked)
            window_size = (window_size * 2 > WINDOW_MAX) ? WINDOW_MAX : window_size * 2;
         else
            window_size = (window_size / 2 < 2) ? 2 : window_size / 2;
         if (rtt_estimate < min_rtt) begin
            rtt_estimate  = init_timeout;
            round_timeout = init_timeout;
         end else begin
            round_timeout = rtt_estimate;
         end
      endfunction

      function void note_event(logic [1:0] mode, logic [SEQ_W-1:0] ack);
         int unsigned       first;
         longint unsigned   frames;
         logic [SEQ_W-1:0]  acked;
         int unsigned       twice;
         send_cmd_t         tail;
         first = expected_sends.size();
         case (mode)
            MODE_START: begin
               frames      = (longint'(total_bytes) + FRAME_BYTES - 1) / FRAME_BYTES;
               frame_count = (frames > SEQ_MAX) ? SEQ_MAX : SEQ_W'(frames);
               last_length = (total_bytes % FRAME_BYTES == 0) ? LEN_W'(FRAME_BYTES)
                                                              : LEN_W'(total_bytes % FRAME_BYTES);
               window_size = init_window;
               if (window_size < 2)
                  window_size = 2;
               if (window_size > WINDOW_MAX)
                  window_size = WINDOW_MAX;
               round_timeout = init_timeout;
               rtt_estimate  = init_timeout;
               base_frame    = '0;
               round_end     = '0;
               elapsed_ms    = '0;
               phase         = XFER_HANDSHAKE;
               push_send(frame_count, '0, 1'b1, 1'b0);
            end
            MODE_ACK: begin
               if (phase == XFER_HANDSHAKE) begin
                  phase      = XFER_RUNNING;
                  base_frame = '0;
                  open_round();
               end else if (phase == XFER_RUNNING) begin
                  acked = (ack > frame_count) ? frame_count : ack;
                  if (acked > base_frame) begin
                     base_frame   = acked;
                     twice        = 2 * elapsed_ms;
                     rtt_estimate = (twice > MS_MAX) ? MS_MAX : MS_W'(twice);
                     if (base_frame >= round_end) begin
                        close_round(1'b1);
                        open_round();
                     end
                  end
               end
            end
            MODE_TICK: begin
               if (phase == XFER_HANDSHAKE) begin
                  push_send(frame_count, '0, 1'b1, 1'b0);
               end else if (phase == XFER_RUNNING) begin
                  if (elapsed_ms < MS_MAX)
                     elapsed_ms++;
                  if (elapsed_ms >= round_timeout) begin
                     close_round(1'b0);
                     open_round();
                  end
               end
            end
            default: ;
         endcase
         if (expected_sends.size() > first) begin
            tail      = expected_sends[expected_sends.size() - 1];
            tail.last = 1'b1;
            expected_sends[expected_sends.size() - 1] = tail;
         end
      endfunction

      function void check_send(logic [SEQ_W-1:0] seq, logic [LEN_W-1:0] len, logic header,
                               logic done, logic last, time at_ns);
         send_cmd_t want;
         if (expected_sends.size() == 0) begin
            mismatches++;
            $display("%0t ns: unexpected send command seq %0d len %0d header %0b done %0b",
                     at_ns, seq, len, header, done);
            return;
         end
         want = expected_sends.pop_front();
         if (want.seq !== seq) begin
            mismatches++;
            $display("%0t ns: send_seq expected %0d actual %0d", at_ns, want.seq, seq);
         end
         if (want.len !== len) begin
            mismatches++;
            $display("%0t ns: send_length expected %0d actual %0d", at_ns, want.len, len);
         end
         if (want.header !== header) begin
            mismatches++;
            $display("%0t ns: is_header expected %0b actual %0b", at_ns, want.header, header);
         end
         if (want.done !== done) begin
            mismatches++;
            $display("%0t ns: transfer_done expected %0b actual %0b", at_ns, want.done, done);
         end
         if (want.last !== last) begin
            mismatches++;
            $display("%0t ns: last_of_run expected %0b actual %0b", at_ns, want.last, last);
         end
      endfunction

   endclass

endpackage

// ----- tb/tb_sliding_window_sender_unit.sv -----
// Top of the sliding window sender testbench: clock, reset, stream and
// register drivers, a directed opening and randomized transfers.
// Depends on sws_pkg, sws_send_check_pkg and sliding_window_sender_unit.
module tb_sliding_window_sender_unit;

   timeunit 1ns;
   timeprecision 1ps;

   import sws_pkg::*;
   import sws_send_check_pkg::*;

   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_ITEMS  = 100;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   send_cmd_scoreboard send_tracker;
   bit                 tx_eager;
   bit                 rx_eager;
   int unsigned        rsp_stall;
   int unsigned        idle_cycles = 0;

   sliding_window_sender_unit uut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Result side: after each transaction the receiver holds off for a drawn
   // number of cycles, unless it is in an eager stretch.
   initial begin
      rsp_tready = 1'b0;
      rsp_stall  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            send_tracker.check_send(rsp_tdata[21:0], rsp_tdata[32:22], rsp_tuser[0],
                                    rsp_tuser[1], rsp_tlast, $time);
            rsp_stall = rx_eager ? 0 : $urandom_range(0, 15);
         end
         @(negedge clock);
         rsp_tready = (rsp_stall == 0);
         if (rsp_stall != 0)
            rsp_stall--;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("sliding_window_sender_unit regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_reg(input logic [IDX_W-1:0] index, input logic [31:0] value);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      send_tracker.note_config(index, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_event(input logic [1:0] mode, input logic [SEQ_W-1:0] ack);
      int unsigned gap;
      gap = tx_eager ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = mode;
      req_tdata  = {2'b00, ack};
      do @(posedge clock); while (!req_tready);
      send_tracker.note_event(mode, ack);
      @(negedge clock);
   endtask

   // Registers may only change once the block has gone quiet.
   task automatic drain();
      req_tvalid = 1'b0;
      while (send_tracker.expected_sends.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_random_config();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 3) != 0)
         write_reg(REG_TOTAL_BYTES,
                   (pick < 6) ? 32'($urandom_range(0, 12 * FRAME_BYTES)) :
                   (pick < 8) ? 32'(FRAME_BYTES * $urandom_range(0, 10)) :
                   (pick == 8) ? 32'd0 : 32'($urandom));
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 3) != 0)
         write_reg(REG_INITIAL_WINDOW,
                   (pick < 6) ? 32'($urandom_range(2, 8)) :
                   (pick < 8) ? 32'($urandom_range(0, 127)) : 32'(WINDOW_MAX));
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 3) != 0)
         write_reg(REG_INITIAL_TIMEOUT,
                   (pick < 7) ? 32'($urandom_range(0, 6)) : 32'($urandom_range(0, 65535)));
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 3) != 0)
         write_reg(REG_MIN_RTT,
                   (pick < 6) ? 32'($urandom_range(0, 12)) : 32'($urandom_range(0, 65535)));
   endtask

   // While running: mostly acks, many moving the base inside the current round,
   // plus ticks, stale acks, wild ack numbers, restarts and the unused mode.
   task automatic send_random_event(inout int unsigned busy_items);
      int unsigned      pick;
      logic [1:0]       mode;
      logic [SEQ_W-1:0] ack;
      pick = $urandom_range(0, 99);
      ack  = SEQ_W'($urandom);
      case (send_tracker.phase)
         XFER_HANDSHAKE: mode = (pick < 30) ? MODE_TICK : MODE_ACK;
         XFER_RUNNING: begin
            if (pick < 45) begin
               mode = MODE_ACK;
               ack  = SEQ_W'($urandom_range(send_tracker.base_frame + 1,
                                            send_tracker.round_end));
            end else if (pick < 55) begin
               mode = MODE_ACK;
               ack  = SEQ_W'($urandom_range(0, send_tracker.base_frame));
            end else if (pick < 62) begin
               mode = MODE_ACK;
            end else if (pick < 94) begin
               mode = MODE_TICK;
            end else if (pick < 97) begin
               mode = MODE_START;
            end else begin
               mode = MODE_UNUSED;
            end
         end
         default: begin
            if (pick < 80)
               mode = MODE_START;
            else if (pick < 88)
               mode = MODE_ACK;
            else if (pick < 96)
               mode = MODE_TICK;
            else
               mode = MODE_UNUSED;
         end
      endcase
      if (mode == MODE_START || (mode != MODE_UNUSED &&
          (send_tracker.phase == XFER_HANDSHAKE || send_tracker.phase == XFER_RUNNING)))
         busy_items++;
      send_event(mode, ack);
   endtask

   initial begin
      int unsigned busy_items;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = MODE_START;
      csr_valid  = 1'b0;
      csr_index  = REG_TOTAL_BYTES;
      csr_data   = '0;
      tx_eager   = 1'b0;
      rx_eager   = 1'b0;
      busy_items = 0;
      send_tracker = new();
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Events while idle are ignored; then an empty transfer with the
      // reset registers completes as soon as the handshake ends.
      send_event(MODE_ACK, SEQ_MAX);
      send_event(MODE_TICK, '0);
      send_event(MODE_UNUSED, 22'h155555);
      send_event(MODE_START, '0);
      send_event(MODE_TICK, '0);
      send_event(MODE_ACK, '0);
      send_event(MODE_ACK, 22'd1);
      send_event(MODE_TICK, 22'h2AAAAA);
      drain();

      // Three full frames, window below the floor, zero timeout and zero
      // minimum rtt: a timeout on the first tick, partial and stale acks,
      // and an ack past the frame count.
      write_reg(REG_TOTAL_BYTES, 32'(3 * FRAME_BYTES));
      write_reg(REG_INITIAL_WINDOW, 32'd0);
      write_reg(REG_INITIAL_TIMEOUT, 32'd0);
      write_reg(REG_MIN_RTT, 32'd0);
      send_event(MODE_START, '0);
      send_event(MODE_ACK, '0);
      send_event(MODE_TICK, '0);
      send_event(MODE_ACK, 22'd1);
      send_event(MODE_ACK, 22'd1);
      send_event(MODE_ACK, 22'd2);
      send_event(MODE_ACK, 22'd9);
      drain();

      // Largest transfer, window above the cap, longest timeout and a
      // minimum rtt that forces the timeout back to its initial value.
      write_reg(REG_TOTAL_BYTES, 32'hFFFF_FFFF);
      write_reg(REG_INITIAL_WINDOW, 32'd127);
      write_reg(REG_INITIAL_TIMEOUT, 32'd65535);
      write_reg(REG_MIN_RTT, 32'd65535);
      send_event(MODE_START, '0);
      send_event(MODE_ACK, 22'h2AAAAA);
      send_event(MODE_ACK, 22'(WINDOW_MAX));
      send_event(MODE_TICK, '0);
      send_event(MODE_UNUSED, '0);
      send_event(MODE_START, SEQ_MAX);

      while (busy_items < RANDOM_ITEMS) begin
         drain();
         write_random_config();
         tx_eager = ($urandom_range(0, 3) == 0);
         rx_eager = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) != 0) begin
            send_event(MODE_START, SEQ_W'($urandom));
            busy_items++;
         end
         repeat ($urandom_range(6, 16)) send_random_event(busy_items);
      end
      drain();

      if (send_tracker.mismatches == 0 && send_tracker.expected_sends.size() == 0)
         $display("sliding_window_sender_unit regression: pass");
      else
         $display("sliding_window_sender_unit regression: fail");
      $finish;
   end

endmodule
